@@ design/pph_pkg.sv @@
// ----------------------------------------------------------------------------
// pph_pkg
// Shared types, constants and the body-start decision of the header stripper.
// ----------------------------------------------------------------------------
package pph_pkg;

  typedef enum logic [2:0] {
    PH_TAG  = 3'd0,
    PH_LEN  = 3'd1,
    PH_HDR  = 3'd2,
    PH_PASS = 3'd3,
    PH_SKIP = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_PK    = 2'd1,
    KIND_SYM   = 2'd2
  } kind_t;

  localparam logic [7:0]  TAG_MASK       = 8'hBC;
  localparam logic [7:0]  TAG_PK         = 8'h84;
  localparam logic [7:0]  TAG_SYM        = 8'hA4;
  localparam logic [1:0]  LEN_TYPE_NONE  = 2'd3;
  localparam logic [31:0] LEN_INDEFINITE = 32'h7FFF_FFFF;
  localparam logic [7:0]  PK_VERSION     = 8'h02;
  localparam logic [7:0]  RSA_VER_BYTE   = 8'h01;
  localparam logic [31:0] HDR_BYTES      = 32'd12;
  localparam logic [3:0]  HDR_LAST_IDX   = 4'd11;
  localparam logic [3:0]  HDR_PKVER_IDX  = 4'd0;
  localparam logic [3:0]  HDR_RSAVER_IDX = 4'd9;

  localparam logic [1:0]  WARN_EXTRA_RSA = 2'd0;
  localparam logic [1:0]  WARN_CONV_RSA  = 2'd1;
  localparam logic [1:0]  WARN_PK_VER    = 2'd2;
  localparam logic [1:0]  WARN_RSA_VER   = 2'd3;

  // One result item
  typedef struct packed {
    logic       valid;
    logic       is_warning;
    logic [7:0] payload_byte;
    logic [1:0] warning_code;
  } result_t;

  // Outcome of a completed length field
  typedef struct packed {
    phase_t     phase;
    logic       warn;
    logic [1:0] code;
  } body_t;

  function automatic logic [2:0] len_bytes(input logic [1:0] len_type);
    logic [2:0] n;
    case (len_type)
      2'd0:    n = 3'd1;
      2'd1:    n = 3'd2;
      2'd2:    n = 3'd4;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic body_t start_body(input kind_t kind, input logic [31:0] len,
                                       input logic rsa_seen, input logic conv);
    body_t  r;
    phase_t body_ph;
    r       = '{phase: PH_TAG, warn: 1'b0, code: WARN_EXTRA_RSA};
    body_ph = PH_SKIP;
    case (kind)
      KIND_PK: begin
        if (rsa_seen) begin
          r.warn = 1'b1;
          r.code = WARN_EXTRA_RSA;
        end else if (conv) begin
          r.warn = 1'b1;
          r.code = WARN_CONV_RSA;
        end
      end
      KIND_SYM: body_ph = PH_PASS;
      default:  body_ph = PH_SKIP;
    endcase
    if (kind == KIND_PK && !rsa_seen && !conv) begin
      r.phase = PH_HDR;
    end else begin
      r.phase = (len == 32'd0) ? PH_TAG : body_ph;
    end
    return r;
  endfunction

endpackage

@@ design/pph_in_stage.sv @@
// ----------------------------------------------------------------------------
// pph_in_stage
// Input register: holds one accepted byte until the parser consumes it.
// ----------------------------------------------------------------------------
module pph_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       consume,
  output logic       vld,
  output logic [7:0] data
);
  logic       vld_r, vld_nxt;
  logic [7:0] data_r;
  logic       take;

  assign in_ready = !vld_r || consume;
  assign take     = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (consume) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      data_r <= in_data_byte;
    end
  end

  assign vld  = vld_r;
  assign data = data_r;
endmodule

@@ design/pph_parser.sv @@
// ----------------------------------------------------------------------------
// pph_parser
// Packet parse state and the per-byte decision.
// ----------------------------------------------------------------------------
module pph_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data,
  input  logic             conv,
  output pph_pkg::result_t res
);
  import pph_pkg::*;

  phase_t      phase_r, phase_nxt;
  kind_t       kind_r, kind_nxt;
  logic [2:0]  len_left_r, len_left_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [3:0]  hdr_r, hdr_nxt;
  logic        rsa_seen_r, rsa_seen_nxt;

  kind_t       tag_kind;
  logic [2:0]  tag_len;
  logic [31:0] len_shift;
  logic [2:0]  len_dec;
  logic [31:0] rem_dec;
  logic [31:0] hdr_rem;
  body_t       tag_body;
  body_t       len_body;

  always_comb begin
    if ((data & TAG_MASK) == TAG_PK) begin
      tag_kind = KIND_PK;
    end else if ((data & TAG_MASK) == TAG_SYM) begin
      tag_kind = KIND_SYM;
    end else begin
      tag_kind = KIND_OTHER;
    end
  end

  assign tag_len   = len_bytes(data[1:0]);
  assign len_shift = {rem_r[23:0], data};
  assign len_dec   = len_left_r - 3'd1;
  assign rem_dec   = rem_r - 32'd1;
  assign hdr_rem   = (rem_r > HDR_BYTES) ? (rem_r - HDR_BYTES) : 32'd0;
  assign tag_body  = start_body(tag_kind, LEN_INDEFINITE, rsa_seen_r, conv);
  assign len_body  = start_body(kind_r, len_shift, rsa_seen_r, conv);

  // Next state
  always_comb begin
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    len_left_nxt = len_left_r;
    rem_nxt      = rem_r;
    hdr_nxt      = hdr_r;
    rsa_seen_nxt = rsa_seen_r;
    case (phase_r)
      PH_TAG: begin
        kind_nxt = tag_kind;
        hdr_nxt  = 4'd0;
        if (data[1:0] == LEN_TYPE_NONE) begin
          len_left_nxt = 3'd0;
          rem_nxt      = LEN_INDEFINITE;
          phase_nxt    = tag_body.phase;
        end else begin
          len_left_nxt = tag_len;
          rem_nxt      = 32'd0;
          phase_nxt    = PH_LEN;
        end
      end
      PH_LEN: begin
        rem_nxt      = len_shift;
        len_left_nxt = len_dec;
        if (len_dec == 3'd0) begin
          phase_nxt = len_body.phase;
          if (len_body.phase == PH_HDR) begin
            hdr_nxt = 4'd0;
          end
        end
      end
      PH_HDR: begin
        hdr_nxt = hdr_r + 4'd1;
        if (hdr_r >= HDR_LAST_IDX) begin
          rsa_seen_nxt = 1'b1;
          rem_nxt      = hdr_rem;
          hdr_nxt      = 4'd0;
          phase_nxt    = (hdr_rem == 32'd0) ? PH_TAG : PH_PASS;
        end
      end
      PH_PASS, PH_SKIP: begin
        rem_nxt = rem_dec;
        if (rem_dec == 32'd0) begin
          phase_nxt = PH_TAG;
        end
      end
      default: phase_nxt = PH_TAG;
    endcase
  end

  // Result
  always_comb begin
    res = '{valid: 1'b0, is_warning: 1'b0, payload_byte: 8'd0, warning_code: 2'd0};
    case (phase_r)
      PH_TAG: begin
        if (data[1:0] == LEN_TYPE_NONE && tag_body.warn) begin
          res.valid        = 1'b1;
          res.is_warning   = 1'b1;
          res.warning_code = tag_body.code;
        end
      end
      PH_LEN: begin
        if (len_dec == 3'd0 && len_body.warn) begin
          res.valid        = 1'b1;
          res.is_warning   = 1'b1;
          res.warning_code = len_body.code;
        end
      end
      PH_HDR: begin
        if (hdr_r == HDR_PKVER_IDX && data != PK_VERSION) begin
          res.valid        = 1'b1;
          res.is_warning   = 1'b1;
          res.warning_code = WARN_PK_VER;
        end else if (hdr_r == HDR_RSAVER_IDX && data != RSA_VER_BYTE) begin
          res.valid        = 1'b1;
          res.is_warning   = 1'b1;
          res.warning_code = WARN_RSA_VER;
        end
      end
      PH_PASS: begin
        res.valid        = 1'b1;
        res.payload_byte = data;
      end
      default: res.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_TAG;
      kind_r     <= KIND_OTHER;
      len_left_r <= 3'd0;
      rem_r      <= 32'd0;
      hdr_r      <= 4'd0;
      rsa_seen_r <= 1'b0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      kind_r     <= kind_nxt;
      len_left_r <= len_left_nxt;
      rem_r      <= rem_nxt;
      hdr_r      <= hdr_nxt;
      rsa_seen_r <= rsa_seen_nxt;
    end
  end
endmodule

@@ design/pph_out_stage.sv @@
// ----------------------------------------------------------------------------
// pph_out_stage
// Result register toward the output channel.
// ----------------------------------------------------------------------------
module pph_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  pph_pkg::result_t res,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             out_is_warning,
  output logic [7:0]       out_payload_byte,
  output logic [1:0]       out_warning_code
);
  import pph_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = res.valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      res_r <= res;
    end
  end

  assign out_valid        = valid_r;
  assign out_is_warning   = res_r.is_warning;
  assign out_payload_byte = res_r.payload_byte;
  assign out_warning_code = res_r.warning_code;
endmodule

@@ design/pgp_packet_header_stripper.sv @@
// ----------------------------------------------------------------------------
// pgp_packet_header_stripper
// Old-format packet stream parser that strips the first public-key header.
// ----------------------------------------------------------------------------
// The block takes one stream byte per transfer and sustains one byte per
// cycle unless the output register is held. A byte lands in an input
// register, is parsed combinationally by the tag / length / header / body
// state, and its result (a payload byte or a warning) is loaded into an
// output register when that register can take it; the result is offered
// from the output register. Bytes that give no result (tags, length bytes,
// stripped header bytes, skipped bodies) still take a parse step.
// Only a held output register throttles intake. The first public-key packet
// loses its 12 header bytes and passes the rest; symmetric packets pass their
// payload; everything else is dropped. Warnings: code 0 extra public-key
// packet, 1 public-key packet in conventional mode, 2 bad key version byte,
// 3 bad RSA version byte. Packet warnings come with the byte that completes
// the length. Write cfg_wr_data (conventional mode) only while idle.
// ----------------------------------------------------------------------------
module pgp_packet_header_stripper (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_is_warning,
  output logic [7:0] out_payload_byte,
  output logic [1:0] out_warning_code
);
  import pph_pkg::*;

  logic       conv_r, conv_nxt;
  logic       byte_vld;
  logic [7:0] byte_data;
  logic       can_load;
  logic       step;
  result_t    res;

  // Configuration register
  assign conv_nxt = cfg_wr_en ? cfg_wr_data : conv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conv_r <= 1'b0;
    end else begin
      conv_r <= conv_nxt;
    end
  end

  // Advance a held byte whenever the output register can take its result
  assign step = byte_vld && can_load;

  pph_in_stage u_in (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .consume      (step),
    .vld          (byte_vld),
    .data         (byte_data)
  );

  pph_parser u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .data  (byte_data),
    .conv  (conv_r),
    .res   (res)
  );

  pph_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (step),
    .res              (res),
    .can_load         (can_load),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_warning   (out_is_warning),
    .out_payload_byte (out_payload_byte),
    .out_warning_code (out_warning_code)
  );
endmodule

@@ design/pph_checker.sv @@
// ----------------------------------------------------------------------------
// pph_checker
// Port-level checks on the header stripper's result channel.
// ----------------------------------------------------------------------------
module pph_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_is_warning,
  input logic [7:0] out_payload_byte,
  input logic [1:0] out_warning_code
);
  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_is_warning) && $stable(out_payload_byte)
      && $stable(out_warning_code))
    else $error("result changed while stalled");

  a_warn_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_warning |-> out_payload_byte == 8'd0)
    else $error("warning carries payload bits");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_is_warning |-> out_warning_code == 2'd0)
    else $error("payload carries warning code");
endmodule

bind pgp_packet_header_stripper pph_checker u_pph_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_is_warning   (out_is_warning),
  .out_payload_byte (out_payload_byte),
  .out_warning_code (out_warning_code)
);

@@ tb/sv/pgp_packet_header_stripper_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgp_packet_header_stripper_tb
// Self-checking bench for the packet header stripper.
// ----------------------------------------------------------------------------
// Feeds a byte stream of old-format packets through the valid/ready input and
// checks every payload byte and warning on the result side. The bench tracks
// the parser state itself as bytes transfer, so each result is compared
// against what the stream dictates. A short directed part opens the run. It
// covers the conventional-mode drop, the one stripped key header with its
// version checks, the extra key packet and empty bodies. Random packets
// follow, in several phases with mode writes in between. A packet that never
// ends (indefinite length, or a 4-byte length with the top bit set) closes
// the stream.
// ----------------------------------------------------------------------------
module pgp_packet_header_stripper_tb;
  import pph_pkg::*;

  typedef struct packed {
    logic       is_warning;
    logic [7:0] payload_byte;
    logic [1:0] warning_code;
  } outcome_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_is_warning;
  logic [7:0] out_payload_byte;
  logic [1:0] out_warning_code;

  logic [7:0] byte_feed[$];     // stream bytes waiting to transfer
  outcome_t   due_results[$];   // results the stream has earned so far
  int         fed_total = 0;
  int         in_count = 0;
  int         out_count = 0;
  int         err_cnt = 0;

  // Parser state as the bench sees it
  phase_t      mp_phase = PH_TAG;
  kind_t       mp_kind = KIND_OTHER;
  logic [2:0]  mp_len_left = '0;
  logic [31:0] mp_remaining = '0;
  logic [3:0]  mp_hdr_idx = '0;
  logic        mp_key_done = 1'b0;
  logic        mp_conv = 1'b0;

  pgp_packet_header_stripper dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data_byte     (in_data_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_is_warning   (out_is_warning),
    .out_payload_byte (out_payload_byte),
    .out_warning_code (out_warning_code)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Stream tracking
  // --------------------------------------------------------------------------
  function automatic void push_warning(input logic [1:0] code);
    due_results.push_back('{is_warning: 1'b1, payload_byte: 8'h00, warning_code: code});
  endfunction

  // Enter a body, or fall straight back to tag hunting when nothing is left.
  function automatic void enter_body(input phase_t ph);
    mp_phase = (mp_remaining == 32'd0) ? PH_TAG : ph;
  endfunction

  // The length is complete: decide what the body does.
  function automatic void open_body();
    if (mp_kind == KIND_PK) begin
      if (mp_key_done) begin
        enter_body(PH_SKIP);
        push_warning(WARN_EXTRA_RSA);
      end else if (mp_conv) begin
        enter_body(PH_SKIP);
        push_warning(WARN_CONV_RSA);
      end else begin
        // Header strip runs even for a zero or short length
        mp_hdr_idx = '0;
        mp_phase   = PH_HDR;
      end
    end else if (mp_kind == KIND_SYM) begin
      enter_body(PH_PASS);
    end else begin
      enter_body(PH_SKIP);
    end
  endfunction

  function automatic void parse_stream_byte(input logic [7:0] b);
    logic [7:0] kind_bits;
    logic [3:0] idx;
    case (mp_phase)
      PH_TAG: begin
        kind_bits = b & TAG_MASK;
        mp_kind   = KIND_OTHER;
        if (kind_bits == TAG_PK) begin
          mp_kind = KIND_PK;
        end else if (kind_bits == TAG_SYM) begin
          mp_kind = KIND_SYM;
        end
        mp_remaining = '0;
        mp_hdr_idx   = '0;
        if (b[1:0] == LEN_TYPE_NONE) begin
          // No length bytes: the tag itself completes the length
          mp_len_left  = '0;
          mp_remaining = LEN_INDEFINITE;
          open_body();
        end else begin
          case (b[1:0])
            2'd0:    mp_len_left = 3'd1;
            2'd1:    mp_len_left = 3'd2;
            default: mp_len_left = 3'd4;
          endcase
          mp_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        mp_remaining = {mp_remaining[23:0], b};
        mp_len_left  = mp_len_left - 3'd1;
        if (mp_len_left == 3'd0) begin
          open_body();
        end
      end
      PH_HDR: begin
        idx        = mp_hdr_idx;
        mp_hdr_idx = mp_hdr_idx + 4'd1;
        if (idx >= HDR_LAST_IDX) begin
          mp_key_done  = 1'b1;
          mp_remaining = (mp_remaining > HDR_BYTES) ? mp_remaining - HDR_BYTES : 32'd0;
          mp_hdr_idx   = '0;
          enter_body(PH_PASS);
        end else if (idx == HDR_PKVER_IDX && b != PK_VERSION) begin
          push_warning(WARN_PK_VER);
        end else if (idx == HDR_RSAVER_IDX && b != RSA_VER_BYTE) begin
          push_warning(WARN_RSA_VER);
        end
      end
      PH_PASS: begin
        mp_remaining = mp_remaining - 32'd1;
        if (mp_remaining == 32'd0) begin
          mp_phase = PH_TAG;
        end
        due_results.push_back('{is_warning: 1'b0, payload_byte: b, warning_code: '0});
      end
      PH_SKIP: begin
        mp_remaining = mp_remaining - 32'd1;
        if (mp_remaining == 32'd0) begin
          mp_phase = PH_TAG;
        end
      end
      default: mp_phase = PH_TAG;
    endcase
  endfunction

  // No idling inside one window of transfers, about 7 in 100 elsewhere
  function automatic int idle_pct(input int n, input int lo);
    return (n >= lo && n < lo + 300) ? 0 : 7;
  endfunction

  // --------------------------------------------------------------------------
  // Input driver: hold valid and the byte until the transfer, then advance
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        parse_stream_byte(in_data_byte);
        in_count++;
      end
      if (!in_valid || in_ready) begin
        if (byte_feed.size() != 0 && $urandom_range(0, 99) >= idle_pct(in_count, 250)) begin
          in_valid     <= 1'b1;
          in_data_byte <= byte_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each transfer with the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    outcome_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_count++;
        if (due_results.size() == 0) begin
          $error("unexpected result: is_warning %0d, payload_byte %02h, warning_code %0d",
                 out_is_warning, out_payload_byte, out_warning_code);
          err_cnt++;
        end else begin
          want = due_results.pop_front();
          if (out_is_warning !== want.is_warning) begin
            $error("is_warning: expected %0d, got %0d", want.is_warning, out_is_warning);
            err_cnt++;
          end
          if (out_payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %02h, got %02h",
                   want.payload_byte, out_payload_byte);
            err_cnt++;
          end
          if (out_warning_code !== want.warning_code) begin
            $error("warning_code: expected %0d, got %0d",
                   want.warning_code, out_warning_code);
            err_cnt++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= idle_pct(out_count, 100));
    end
  end

  // --------------------------------------------------------------------------
  // Stream building
  // --------------------------------------------------------------------------
  task automatic feed(input logic [7:0] b);
    byte_feed.push_back(b);
    fed_total++;
  endtask

  task automatic send_body(input int n);
    repeat (n) feed(8'($urandom_range(0, 255)));
  endtask

  // Tag, then the big-endian length in as many bytes as the tag asks
  task automatic send_header(input logic [7:0] tag, input logic [31:0] len);
    feed(tag);
    case (tag[1:0])
      2'd0: feed(len[7:0]);
      2'd1: begin
        feed(len[15:8]);
        feed(len[7:0]);
      end
      2'd2: begin
        feed(len[31:24]);
        feed(len[23:16]);
        feed(len[15:8]);
        feed(len[7:0]);
      end
      default: ;
    endcase
  endtask

  // Randomize the bits the parser ignores (bit 6) around the kind bits
  function automatic logic [7:0] make_tag(input kind_t k, input logic [1:0] len_type);
    logic [7:0] t;
    case (k)
      KIND_PK:  t = TAG_PK;
      KIND_SYM: t = TAG_SYM;
      default: begin
        do t = 8'($urandom_range(0, 255)) & TAG_MASK;
        while (t == TAG_PK || t == TAG_SYM);
      end
    endcase
    t[6]   = 1'($urandom_range(0, 1));
    t[1:0] = len_type;
    return t;
  endfunction

  // One complete packet; lengths stay small so every body finishes
  task automatic random_packet();
    int          pick;
    logic [1:0]  lt;
    logic [31:0] len;
    logic [7:0]  tag;
    pick = $urandom_range(0, 99);
    lt   = 2'($urandom_range(0, 2));
    len  = ($urandom_range(0, 11) == 0) ? $urandom_range(25, 255) : $urandom_range(0, 24);
    if (lt == 2'd1 && $urandom_range(0, 19) == 0) begin
      len = 32'h100 + $urandom_range(0, 40);
    end
    if (pick < 45) begin
      tag = make_tag(KIND_SYM, lt);
    end else if (pick < 65) begin
      tag = make_tag(KIND_PK, lt);
    end else if (pick < 90) begin
      tag = make_tag(KIND_OTHER, lt);
    end else begin
      // Stray tag: any kind bits at all
      tag      = 8'($urandom_range(0, 255));
      tag[1:0] = lt;
    end
    send_header(tag, len);
    send_body(len);
  endtask

  // Wait until every byte has transferred and every result has come back,
  // then let the last bytes without a result clear the pipeline.
  task automatic drain_and_settle();
    int waited = 0;
    do @(negedge clk); while (byte_feed.size() != 0 || in_valid);
    while (due_results.size() != 0 && waited < 2000) begin
      @(negedge clk);
      waited++;
    end
    if (due_results.size() != 0) begin
      $error("%0d expected results never arrived", due_results.size());
      err_cnt++;
      due_results.delete();
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic write_conv(input logic v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    mp_conv = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [31:0] strip_len;
    logic [7:0]  tail_tag;
    int          phase_fed;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Conventional mode: drop key packets with a warning, one with an empty body
    write_conv(1'b1);
    send_header(make_tag(KIND_PK, 2'd0), 32'd0);
    send_header(make_tag(KIND_PK, 2'd0), 32'd2);
    send_body(2);
    drain_and_settle();

    // Normal mode: strip the one key header, short or with payload behind it
    write_conv(1'b0);
    strip_len = $urandom_range(0, 1) ? 32'd14 : 32'($urandom_range(0, 11));
    send_header(make_tag(KIND_PK, 2'd1), strip_len);
    feed($urandom_range(0, 1) ? PK_VERSION : 8'hFF);
    send_body(8);
    feed($urandom_range(0, 1) ? RSA_VER_BYTE : 8'h00);
    send_body(2);
    send_body((strip_len > HDR_BYTES) ? int'(strip_len - HDR_BYTES) : 0);
    // Any later key packet is extra
    send_header(make_tag(KIND_PK, 2'd0), 32'd0);
    // Symmetric packet with a 4-byte length, other packet with an empty body
    send_header(make_tag(KIND_SYM, 2'd2), 32'd1);
    feed(8'hFF);
    send_header(8'h00, 32'd0);
    drain_and_settle();

    // Random phases, each under its own mode setting
    while (fed_total < 900) begin
      write_conv(1'($urandom_range(0, 1)));
      phase_fed = fed_total;
      while (fed_total - phase_fed < 120 && fed_total < 900) begin
        random_packet();
      end
      drain_and_settle();
    end

    // Close with a packet that never ends: indefinite, or a huge 4-byte count
    write_conv(1'($urandom_range(0, 1)));
    tail_tag = make_tag($urandom_range(0, 1) ? KIND_PK : KIND_SYM,
                        $urandom_range(0, 1) ? LEN_TYPE_NONE : 2'd2);
    send_header(tail_tag, {1'b1, 31'($urandom)});
    send_body(40);
    drain_and_settle();
    repeat (10) @(negedge clk);

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hard stop in case the stream stalls
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

@@ filelist.f @@
design/pph_pkg.sv
design/pph_in_stage.sv
design/pph_parser.sv
design/pph_out_stage.sv
design/pgp_packet_header_stripper.sv
design/pph_checker.sv
tb/sv/pgp_packet_header_stripper_tb.sv
